>>> hdl/assert_macros.svh
// Assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hdl/tatan_pkg.sv
// Package: widths, constants and arctangent table for the atan2 block
package tatan_pkg;
    localparam int COORD_BITS = 16;
    localparam int OUT_BITS = 19;
    localparam int PROD_BITS = COORD_BITS + 8;
    localparam int MAG_BITS = PROD_BITS;
    localparam int IDX_BITS = 7;
    localparam int DIV_STEPS = PROD_BITS;
    localparam int INV_BITS = 14;
    localparam int ROM_LAST = 100;
    localparam int RATIO_SCALE = 100;
    localparam int INV_SCALE = 10000;
    localparam int QUARTER_MDEG = 90000;
    localparam int HALF_MDEG = 180000;
    localparam int QDEPTH = 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OUT_BITS-1:0] t_angle;

    typedef enum logic [1:0] {
        K_RATIO = 2'd0,
        K_POS90 = 2'd1,
        K_NEG90 = 2'd2,
        K_ZERO  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [PROD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
        logic                 z_neg;
        logic                 x_neg;
        logic                 y_neg;
    } t_job;

    function automatic logic [15:0] atan_rom(input logic [IDX_BITS-1:0] i);
        logic [15:0] r;
        case (i)
            7'd0: r=0; 7'd1: r=573; 7'd2: r=1146; 7'd3: r=1718; 7'd4: r=2291;
            7'd5: r=2862; 7'd6: r=3434; 7'd7: r=4004; 7'd8: r=4574; 7'd9: r=5143;
            7'd10: r=5711; 7'd11: r=6277; 7'd12: r=6843; 7'd13: r=7407;
            7'd14: r=7970; 7'd15: r=8531; 7'd16: r=9090; 7'd17: r=9648;
            7'd18: r=10204; 7'd19: r=10758; 7'd20: r=11310; 7'd21: r=11860;
            7'd22: r=12407; 7'd23: r=12953; 7'd24: r=13496; 7'd25: r=14036;
            7'd26: r=14574; 7'd27: r=15110; 7'd28: r=15642; 7'd29: r=16172;
            7'd30: r=16699; 7'd31: r=17223; 7'd32: r=17745; 7'd33: r=18263;
            7'd34: r=18778; 7'd35: r=19290; 7'd36: r=19799; 7'd37: r=20304;
            7'd38: r=20807; 7'd39: r=21306; 7'd40: r=21801; 7'd41: r=22294;
            7'd42: r=22782; 7'd43: r=23268; 7'd44: r=23749; 7'd45: r=24228;
            7'd46: r=24702; 7'd47: r=25174; 7'd48: r=25641; 7'd49: r=26105;
            7'd50: r=26565; 7'd51: r=27022; 7'd52: r=27474; 7'd53: r=27924;
            7'd54: r=28369; 7'd55: r=28811; 7'd56: r=29249; 7'd57: r=29683;
            7'd58: r=30114; 7'd59: r=30541; 7'd60: r=30964; 7'd61: r=31383;
            7'd62: r=31799; 7'd63: r=32211; 7'd64: r=32619; 7'd65: r=33024;
            7'd66: r=33425; 7'd67: r=33822; 7'd68: r=34216; 7'd69: r=34606;
            7'd70: r=34992; 7'd71: r=35375; 7'd72: r=35754; 7'd73: r=36129;
            7'd74: r=36501; 7'd75: r=36870; 7'd76: r=37235; 7'd77: r=37596;
            7'd78: r=37954; 7'd79: r=38309; 7'd80: r=38660; 7'd81: r=39007;
            7'd82: r=39352; 7'd83: r=39693; 7'd84: r=40030; 7'd85: r=40365;
            7'd86: r=40696; 7'd87: r=41023; 7'd88: r=41348; 7'd89: r=41669;
            7'd90: r=41987; 7'd91: r=42302; 7'd92: r=42614; 7'd93: r=42923;
            7'd94: r=43229; 7'd95: r=43531; 7'd96: r=43831; 7'd97: r=44128;
            7'd98: r=44421; 7'd99: r=44712; 7'd100: r=45000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction
endpackage

>>> hdl/tatan_front.sv
// Front end: takes coordinate pairs, classifies them and forms the ratio operands
module tatan_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tatan_pkg::t_coord    i_coord_y,
    input  tatan_pkg::t_coord    i_coord_x,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output tatan_pkg::t_job      o_job
);
    import tatan_pkg::*;

    logic                   r_valid;
    t_job                   r_job;
    t_job                   n_job;
    logic [COORD_BITS-1:0]  w_ay;
    logic [COORD_BITS-1:0]  w_ax;
    logic [PROD_BITS-1:0]   w_ay_ext;

    always_comb begin
        w_ay = i_coord_y[COORD_BITS-1] ? (~i_coord_y + 1'b1) : i_coord_y;
        w_ax = i_coord_x[COORD_BITS-1] ? (~i_coord_x + 1'b1) : i_coord_x;
        w_ay_ext = PROD_BITS'(w_ay);
        n_job.num = (w_ay_ext << 6) + (w_ay_ext << 5) + (w_ay_ext << 2);
        n_job.den = w_ax;
        n_job.y_neg = i_coord_y[COORD_BITS-1];
        n_job.x_neg = i_coord_x[COORD_BITS-1];
        n_job.z_neg = i_coord_y[COORD_BITS-1] ^ i_coord_x[COORD_BITS-1];
        if (i_coord_x != '0) begin
            n_job.kind = K_RATIO;
        end else if (i_coord_y == '0) begin
            n_job.kind = K_ZERO;
        end else if (i_coord_y[COORD_BITS-1]) begin
            n_job.kind = K_NEG90;
        end else begin
            n_job.kind = K_POS90;
        end
    end

    assign o_ready = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end
endmodule

>>> hdl/tatan_queue.sv
// Short FIFO between front end and back end
module tatan_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tatan_pkg::t_job  i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output tatan_pkg::t_job  o_job
);
    import tatan_pkg::*;

    t_job       r_mem [QDEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_job;
    end
endmodule

>>> hdl/tatan_back.sv
// Back end: pipelined dividers, table lookup and quadrant correction
module tatan_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tatan_pkg::t_job  i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output tatan_pkg::t_angle o_angle_mdeg
);
    import tatan_pkg::*;

    localparam int NST = DIV_STEPS + INV_BITS + 3;

    // per-stage control and operands
    logic                   r_v   [NST+1];
    t_kind                  r_k   [NST+1];
    logic                   r_zn  [NST+1];
    logic                   r_xn  [NST+1];
    logic                   r_yn  [NST+1];
    logic [PROD_BITS-1:0]   r_q   [DIV_STEPS+1];
    logic [COORD_BITS:0]    r_rem [DIV_STEPS+1];
    logic [COORD_BITS-1:0]  r_d   [DIV_STEPS+1];
    logic [INV_BITS-1:0]    r_iq  [DIV_STEPS+1:DIV_STEPS+INV_BITS+1];
    logic [MAG_BITS:0]      r_ir  [DIV_STEPS+1:DIV_STEPS+INV_BITS+1];
    logic [MAG_BITS-1:0]    r_mag [DIV_STEPS+1:DIV_STEPS+INV_BITS+1];
    logic [16:0]            r_am;
    t_angle                 r_out;
    logic                   w_adv;

    assign w_adv = !r_v[NST] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[NST];
    assign o_angle_mdeg = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NST; s++) r_v[s] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NST; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k[0] <= i_job.kind;
            r_zn[0] <= i_job.z_neg;
            r_xn[0] <= i_job.x_neg;
            r_yn[0] <= i_job.y_neg;
            r_q[0] <= i_job.num;
            r_rem[0] <= '0;
            r_d[0] <= i_job.den;
            for (int s = 1; s <= NST; s++) begin
                r_k[s] <= r_k[s-1];
                r_zn[s] <= r_zn[s-1];
                r_xn[s] <= r_xn[s-1];
                r_yn[s] <= r_yn[s-1];
            end
            // restoring division |y|*100 / |x|, one quotient bit per stage
            for (int s = 1; s <= DIV_STEPS; s++) begin
                logic [COORD_BITS:0] t;
                logic [COORD_BITS:0] dd;
                t = {r_rem[s-1][COORD_BITS-1:0], r_q[s-1][PROD_BITS-1]};
                dd = {1'b0, r_d[s-1]};
                if (t >= dd) begin
                    r_rem[s] <= t - dd;
                    r_q[s] <= {r_q[s-1][PROD_BITS-2:0], 1'b1};
                end else begin
                    r_rem[s] <= t;
                    r_q[s] <= {r_q[s-1][PROD_BITS-2:0], 1'b0};
                end
                r_d[s] <= r_d[s-1];
            end
            // 10000 / |z|, one bit per stage
            r_mag[DIV_STEPS+1] <= r_q[DIV_STEPS];
            r_iq[DIV_STEPS+1] <= INV_BITS'(INV_SCALE);
            r_ir[DIV_STEPS+1] <= '0;
            for (int s = DIV_STEPS+2; s <= DIV_STEPS+INV_BITS+1; s++) begin
                logic [MAG_BITS:0] t2;
                t2 = {r_ir[s-1][MAG_BITS-1:0], r_iq[s-1][INV_BITS-1]};
                if (r_mag[s-1] != '0 && t2 >= {1'b0, r_mag[s-1]}) begin
                    r_ir[s] <= t2 - {1'b0, r_mag[s-1]};
                    r_iq[s] <= {r_iq[s-1][INV_BITS-2:0], 1'b1};
                end else begin
                    r_ir[s] <= t2;
                    r_iq[s] <= {r_iq[s-1][INV_BITS-2:0], 1'b0};
                end
                r_mag[s] <= r_mag[s-1];
            end
            // table lookup
            if (r_mag[DIV_STEPS+INV_BITS+1] <= MAG_BITS'(ROM_LAST)) begin
                r_am <= 17'(atan_rom(IDX_BITS'(r_mag[DIV_STEPS+INV_BITS+1])));
            end else begin
                r_am <= 17'(QUARTER_MDEG)
                      - 17'(atan_rom(IDX_BITS'(r_iq[DIV_STEPS+INV_BITS+1])));
            end
            // sign and quadrant
            begin
                t_angle a;
                a = r_zn[NST-1] ? -t_angle'(r_am) : t_angle'(r_am);
                case (r_k[NST-1])
                    K_POS90: r_out <= t_angle'(QUARTER_MDEG);
                    K_NEG90: r_out <= -t_angle'(QUARTER_MDEG);
                    K_ZERO:  r_out <= '0;
                    default: begin
                        if (!r_xn[NST-1]) r_out <= a;
                        else if (!r_yn[NST-1]) r_out <= a + t_angle'(HALF_MDEG);
                        else r_out <= a - t_angle'(HALF_MDEG);
                    end
                endcase
            end
        end
    end
endmodule

>>> hdl/table_atan2_millidegrees.sv
// Throughput: one coordinate pair per cycle when the output is not stalled; the divider stages are fully pipelined.
// The ratio and reciprocal dividers are bit-serial stages, one quotient bit each.
// Reset: synchronous active-low i_rst_n clears all valid flags and queue pointers.
// Top level: atan2 in millidegrees from a signed coordinate pair
module table_atan2_millidegrees (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  tatan_pkg::t_coord       i_coord_y,
    input  tatan_pkg::t_coord       i_coord_x,
    output logic                    o_valid,
    input  logic                    i_ready,
    output tatan_pkg::t_angle       o_angle_mdeg
);
    import tatan_pkg::*;

    logic w_fv, w_fr, w_qv, w_qr;
    t_job w_fjob, w_qjob;

    tatan_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_coord_y(i_coord_y), .i_coord_x(i_coord_x),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fjob)
    );

    tatan_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_ready(w_fr),
        .i_job(w_fjob), .o_valid(w_qv), .i_ready(w_qr), .o_job(w_qjob)
    );

    tatan_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_job(w_qjob), .o_valid(o_valid), .i_ready(i_ready),
        .o_angle_mdeg(o_angle_mdeg)
    );
endmodule

>>> hdl/tatan_checker.sv
// Port-level checker for the atan2 block, bound to the top level
`include "assert_macros.svh"
module tatan_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input tatan_pkg::t_angle o_angle_mdeg
);
    import tatan_pkg::*;

    `ASSERT_RST(a_rst_quiet, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `ASSERT_CLK(a_range, i_clk, i_rst_n, o_valid |-> (o_angle_mdeg <= t_angle'(HALF_MDEG)) && (o_angle_mdeg >= -t_angle'(HALF_MDEG)), "angle out of range")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_angle_mdeg), "stalled result changed")
    `ASSERT_CLK(a_no_early, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_valid, "result without input")
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready |=> i_valid, "input dropped")
endmodule

bind table_atan2_millidegrees tatan_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_angle_mdeg(o_angle_mdeg)
);
